@@ rtl/blpht_pkg.sv @@
// Package: shared constants, codes and types of the bounded linear-probe hash table.
`timescale 1ns / 1ps
package blpht_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefProbeLimit = 16;
  localparam int unsigned DefKeyWidth   = 64;

  localparam int unsigned HashW   = 32;
  localparam int unsigned KeyInW  = 64;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned EntryW  = 11;
  localparam int unsigned SizeW   = 4;

  localparam logic [SizeW-1:0] SizeReset = 4'd10;
  localparam logic [SizeW-1:0] SizeMin   = 4'd4;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [StatusW-1:0] ST_ADDED      = 3'd0;
  localparam logic [StatusW-1:0] ST_UPDATED    = 3'd1;
  localparam logic [StatusW-1:0] ST_SET_FAILED = 3'd2;
  localparam logic [StatusW-1:0] ST_FOUND      = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [StatusW-1:0] ST_REMOVED    = 3'd5;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP
  } seq_state_e;

  typedef struct packed {
    logic empty;
    logic match;
  } cmp_t;

endpackage

@@ rtl/blpht_mem.sv @@
// Single-port slot memory with registered read data.
`timescale 1ns / 1ps
module blpht_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/blpht_cmp.sv @@
// Slot compare unit: empty test and hash-and-key match for one probed slot.
`timescale 1ns / 1ps
module blpht_cmp
  import blpht_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = DefKeyWidth
) (
  input  logic [HashW-1:0]     hash_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [HashW-1:0]     slot_hash_i,
  input  logic [KEY_WIDTH-1:0] slot_key_i,
  output cmp_t                 cmp_o
);

  always_comb begin
    cmp_o.empty = (slot_hash_i == '0);
    cmp_o.match = (slot_hash_i == hash_i) && (slot_key_i == key_i);
  end

endmodule

@@ rtl/bounded_linear_probe_hash_table.sv @@
// Top level: request sequencer, probe datapath and entry counter of the hash table.
`timescale 1ns / 1ps
// After reset the block clears its slot memory, one slot per cycle; busy is high
// meanwhile and size writes are still taken. A request with a zero key hash or
// opcode three is answered without probing: done_o pulses in the cycle right after
// it is taken. Any other request probes slots on the single memory port, each probe a
// slot read in S_READ and then a compare in S_CMP, for 1 to PROBE_LIMIT probes, and
// done_o pulses in the cycle after the last compare. Busy is low during that pulse, so
// the next request can start then. The done_o strobe is high for one cycle only and
// cannot be held off.
module bounded_linear_probe_hash_table
  import blpht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned PROBE_LIMIT = DefProbeLimit,
  parameter int unsigned KEY_WIDTH   = DefKeyWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SizeW-1:0]   cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [HashW-1:0]   key_hash_i,
  input  logic [KeyInW-1:0]  key_i,
  input  logic [ValueW-1:0]  value_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [ValueW-1:0]  read_value_o,
  output logic [SlotW-1:0]   slot_index_o,
  output logic [EntryW-1:0]  entry_count_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PrbW  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int unsigned WordW = HashW + KEY_WIDTH + ValueW;
  localparam logic [PrbW-1:0] LastProbe = PrbW'(PROBE_LIMIT - 1);

  seq_state_e state_q, state_d;

  logic [SizeW-1:0]     size_q, size_d;
  logic [1:0]           op_q, op_d;
  logic [HashW-1:0]     hash_q, hash_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [ValueW-1:0]    val_q, val_d;
  logic [IdxW-1:0]      mask_q, mask_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [PrbW-1:0]      prb_q, prb_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      clr_q, clr_d;
  logic                 done_q, done_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [ValueW-1:0]    rval_q, rval_d;
  logic [IdxW-1:0]      slot_q, slot_d;

  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_addr;
  logic [WordW-1:0]     mem_wdata, mem_rdata;
  logic [HashW-1:0]     rd_hash;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [ValueW-1:0]    rd_val;
  cmp_t                 cmp;
  logic                 hit;
  logic                 bypass;
  logic [SizeW-1:0]     size_eff;
  logic [IdxW-1:0]      new_mask;

  assign rd_hash = mem_rdata[WordW-1 -: HashW];
  assign rd_key  = mem_rdata[ValueW +: KEY_WIDTH];
  assign rd_val  = mem_rdata[ValueW-1:0];

  blpht_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WordW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  blpht_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .hash_i      (hash_q),
    .key_i       (key_q),
    .slot_hash_i (rd_hash),
    .slot_key_i  (rd_key),
    .cmp_o       (cmp)
  );

  assign size_d   = cfg_we_i ? cfg_wdata_i : size_q;
  assign size_eff = (size_q < SizeMin) ? SizeMin : size_q;

  always_comb begin
    for (int b = 0; b < IdxW; b++) begin
      new_mask[b] = ({1'b0, 4'(b)} < {1'b0, size_eff});
    end
  end

  assign bypass = (key_hash_i == '0) || !((opcode_i == OP_GET) || (opcode_i == OP_SET) ||
                                          (opcode_i == OP_REMOVE));
  assign hit    = (op_q == OP_SET) ? (cmp.empty || cmp.match) : cmp.match;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start && !bypass) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit || (prb_q == LastProbe)) state_d = S_IDLE;
        else state_d = S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d      = op_q;
    hash_d    = hash_q;
    key_d     = key_q;
    val_d     = val_q;
    mask_d    = mask_q;
    idx_d     = idx_q;
    prb_d     = prb_q;
    count_d   = count_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    status_d  = status_q;
    rval_d    = rval_q;
    slot_d    = slot_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          op_d   = opcode_i;
          hash_d = key_hash_i;
          key_d  = key_i[KEY_WIDTH-1:0];
          val_d  = value_i;
          mask_d = new_mask;
          idx_d  = key_hash_i[IdxW-1:0] & new_mask;
          prb_d  = '0;
          if (bypass) begin
            done_d   = 1'b1;
            status_d = (opcode_i == OP_SET) ? ST_SET_FAILED : ST_NOT_FOUND;
            rval_d   = '0;
            slot_d   = '0;
          end
        end
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_CMP: begin
        rval_d = '0;
        slot_d = '0;
        if (hit) begin
          done_d = 1'b1;
          slot_d = idx_q;
          case (op_q)
            OP_SET: begin
              mem_we = 1'b1;
              if (cmp.empty) begin
                mem_wdata = {hash_q, key_q, val_q};
                count_d   = count_q + 1'b1;
                status_d  = ST_ADDED;
              end else begin
                mem_wdata = {rd_hash, rd_key, val_q};
                status_d  = ST_UPDATED;
              end
            end
            OP_GET: begin
              status_d = ST_FOUND;
              rval_d   = rd_val;
            end
            default: begin
              mem_we    = 1'b1;
              mem_wdata = {{HashW{1'b0}}, rd_key, rd_val};
              if (count_q != '0) count_d = count_q - 1'b1;
              status_d  = ST_REMOVED;
            end
          endcase
        end else if (prb_q == LastProbe) begin
          done_d   = 1'b1;
          status_d = (op_q == OP_SET) ? ST_SET_FAILED : ST_NOT_FOUND;
        end else begin
          idx_d = (idx_q + 1'b1) & mask_q;
          prb_d = prb_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      size_q  <= SizeReset;
      count_q <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
      prb_q   <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      prb_q   <= prb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    hash_q   <= hash_d;
    key_q    <= key_d;
    val_q    <= val_d;
    mask_q   <= mask_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    rval_q   <= rval_d;
    slot_q   <= slot_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rval_q;
  assign slot_index_o  = SlotW'(slot_q);
  assign entry_count_o = EntryW'(count_q);

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result word strobed while sequencer not idle");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ($past(state_q) == S_READ))
    else $error("compare without a preceding slot read");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");
`endif

endmodule
